@@ hdl/erl_pkg.sv @@
package erl_pkg;

   localparam int LOG_DEPTH = 32;
   localparam int SLOT_W    = $clog2(LOG_DEPTH);
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;

   localparam slot_type LAST_AGE = slot_type'(LOG_DEPTH - 1);

   typedef enum logic [1:0] {
      FUNC_LOG  = 2'd0,
      FUNC_MARK = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [31:0]        stamp;
      logic [7:0]         event_kind;
      logic signed [31:0] event_value;
      logic [5:0]         slot;
   } req_type;

   typedef struct packed {
      logic [31:0]        read_stamp;
      logic [7:0]         read_kind;
      logic signed [31:0] read_value;
      logic               read_ok;
      logic [4:0]         pending_slot;
      logic               pending_found;
      logic [5:0]         stored_count;
      logic               overwrite_alarm;
      logic               alarm_raised;
      logic               alarm_cleared;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        stamp;
      logic [7:0]         kind;
      logic signed [31:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type RESET_ENTRY = '{stamp: 32'd0, kind: 8'd0, value: -32'sd500};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     exec;
      logic     walk;
      slot_type age;
      logic     load;
   } ctrl_type;

endpackage

@@ hdl/event_ring_log_with_sent_marks.sv @@
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  erl_pkg::req_type
// rsp_      out        rsp_valid / rsp_ready  erl_pkg::rsp_type
// csr_      in         csr_write_enable       csr_write_data (report enable)
//
// an item runs from acceptance to rsp_valid through an execute state, a walk of the
// LOG_DEPTH slots via the shared slot subtractor and the entry ram, a drain state for the
// ram read latency and a done state that loads the result; req_ready is high only while idle
// the block goes idle once the result is loaded, so the next item runs while it waits
// and then holds in its load cycle until rsp_ready frees the result register
// synchronous active-high reset; per-slot valid bits stand in for the entry reset values
module event_ring_log_with_sent_marks (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  erl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output erl_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   erl_pkg::ctrl_type  ctrl;
   erl_pkg::req_type   item_ff;
   erl_pkg::rsp_type   rsp_ff, rsp_in;
   erl_pkg::slot_type  newest_ff;
   erl_pkg::slot_type  operand;
   erl_pkg::slot_type  unit_slot;
   erl_pkg::slot_type  pend;
   erl_pkg::count_type count;
   erl_pkg::entry_type wr_entry, rd_entry;

   logic [erl_pkg::LOG_DEPTH-1:0] sent_ff;
   logic [erl_pkg::LOG_DEPTH-1:0] valid_ff;
   logic [erl_pkg::SLOT_W:0]      unit_wide;
   logic [erl_pkg::ENTRY_W-1:0]   ram_q;

   logic req_accept, out_free;
   logic rsp_valid_ff;
   logic enable_ff, alarm_ff, raised_ff, cleared_ff;
   logic slot_in_range;
   logic ram_wr, ram_rd, read_issue;
   logic valid_q_ff, rd_cap_ff;
   logic found;
   logic [31:0]        rd_stamp_ff;
   logic [7:0]         rd_kind_ff;
   logic signed [31:0] rd_value_ff;
   logic               rd_ok_ff;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   erl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .out_free   (out_free),
      .req_ready  (req_ready),
      .ctrl       (ctrl)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
   end

   assign slot_in_range = int'(item_ff.slot) < erl_pkg::LOG_DEPTH;

   // shared slot unit: newest minus age, modulo depth; age depth-1 gives newest+1
   always_comb begin
      operand = ctrl.age;
      if (ctrl.exec) begin
         operand = (item_ff.func == erl_pkg::FUNC_LOG) ? erl_pkg::LAST_AGE
                                                       : item_ff.slot[erl_pkg::SLOT_W-1:0];
      end
      unit_wide = {1'b0, newest_ff} + (erl_pkg::SLOT_W + 1)'(erl_pkg::LOG_DEPTH)
                  - {1'b0, operand};
      if (int'(unit_wide) >= erl_pkg::LOG_DEPTH) begin
         unit_wide = unit_wide - (erl_pkg::SLOT_W + 1)'(erl_pkg::LOG_DEPTH);
      end
      unit_slot = unit_wide[erl_pkg::SLOT_W-1:0];
   end

   assign read_issue = ctrl.exec && item_ff.func == erl_pkg::FUNC_READ && slot_in_range;
   assign ram_wr     = ctrl.exec && item_ff.func == erl_pkg::FUNC_LOG;
   assign ram_rd     = read_issue || ctrl.walk;

   assign wr_entry.stamp = item_ff.stamp;
   assign wr_entry.kind  = item_ff.event_kind;
   assign wr_entry.value = item_ff.event_value;

   erl_ram #(
      .WIDTH (erl_pkg::ENTRY_W),
      .DEPTH (erl_pkg::LOG_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (unit_slot),
      .wr_data (wr_entry),
      .rd_en   (ram_rd),
      .rd_addr (unit_slot),
      .rd_data (ram_q)
   );

   // never-written slots read back as the reset entry
   always_ff @(posedge clock) begin
      if (ram_rd) begin
         valid_q_ff <= valid_ff[unit_slot];
      end
   end

   assign rd_entry = valid_q_ff ? erl_pkg::entry_type'(ram_q) : erl_pkg::RESET_ENTRY;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff  <= '0;
         alarm_ff   <= 1'b0;
         raised_ff  <= 1'b0;
         cleared_ff <= 1'b0;
         sent_ff    <= '1;
         valid_ff   <= '0;
         rd_cap_ff  <= 1'b0;
      end else begin
         rd_cap_ff <= read_issue;
         if (ctrl.exec) begin
            raised_ff  <= 1'b0;
            cleared_ff <= 1'b0;
            unique case (item_ff.func)
               erl_pkg::FUNC_LOG: begin
                  newest_ff           <= unit_slot;
                  valid_ff[unit_slot] <= 1'b1;
                  sent_ff[unit_slot]  <= 1'b0;
                  if (!sent_ff[unit_slot] && enable_ff && !alarm_ff) begin
                     alarm_ff  <= 1'b1;
                     raised_ff <= 1'b1;
                  end
                  if (sent_ff[unit_slot] && enable_ff && alarm_ff) begin
                     alarm_ff   <= 1'b0;
                     cleared_ff <= 1'b1;
                  end
               end
               erl_pkg::FUNC_MARK: begin
                  if (slot_in_range) begin
                     sent_ff[item_ff.slot[erl_pkg::SLOT_W-1:0]] <= 1'b1;
                  end
               end
               erl_pkg::FUNC_READ: begin
               end
               erl_pkg::FUNC_NOP: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         rd_stamp_ff <= '0;
         rd_kind_ff  <= '0;
         rd_value_ff <= '0;
         rd_ok_ff    <= 1'b0;
      end else if (rd_cap_ff) begin
         rd_stamp_ff <= rd_entry.stamp;
         rd_kind_ff  <= rd_entry.kind;
         rd_value_ff <= rd_entry.value;
         rd_ok_ff    <= 1'b1;
      end
   end

   erl_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .addr     (unit_slot),
      .sent_bit (sent_ff[unit_slot]),
      .kind     (rd_entry.kind),
      .pend     (pend),
      .found    (found),
      .count    (count)
   );

   always_comb begin
      rsp_in.read_stamp      = rd_stamp_ff;
      rsp_in.read_kind       = rd_kind_ff;
      rsp_in.read_value      = rd_value_ff;
      rsp_in.read_ok         = rd_ok_ff;
      rsp_in.pending_slot    = 5'(pend);
      rsp_in.pending_found   = found;
      rsp_in.stored_count    = 6'(count);
      rsp_in.overwrite_alarm = alarm_ff;
      rsp_in.alarm_raised    = raised_ff;
      rsp_in.alarm_cleared   = cleared_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/erl_ram.sv @@
module erl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/erl_ctrl.sv @@
module erl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              out_free,
   output logic              req_ready,
   output erl_pkg::ctrl_type ctrl
);

   erl_pkg::state_type state_ff, state_in;
   erl_pkg::slot_type  age_ff, age_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         erl_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = erl_pkg::ST_EXEC;
            end
         end
         erl_pkg::ST_EXEC: begin
            state_in = erl_pkg::ST_WALK;
         end
         erl_pkg::ST_WALK: begin
            if (age_ff == erl_pkg::LAST_AGE) begin
               state_in = erl_pkg::ST_DRAIN;
            end
         end
         erl_pkg::ST_DRAIN: begin
            state_in = erl_pkg::ST_DONE;
         end
         erl_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = erl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl.exec = 1'b0;
      ctrl.walk = 1'b0;
      ctrl.load = 1'b0;
      ctrl.age  = age_ff;
      unique case (state_ff)
         erl_pkg::ST_IDLE:  req_ready = 1'b1;
         erl_pkg::ST_EXEC:  ctrl.exec = 1'b1;
         erl_pkg::ST_WALK:  ctrl.walk = 1'b1;
         erl_pkg::ST_DRAIN: ctrl.load = 1'b0;
         erl_pkg::ST_DONE:  ctrl.load = out_free;
         default:           req_ready = 1'b0;
      endcase
   end

   // age walks 0 .. depth-1 back from the newest slot
   always_comb begin
      age_in = age_ff;
      if (ctrl.exec) begin
         age_in = '0;
      end else if (ctrl.walk) begin
         age_in = age_ff + erl_pkg::slot_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erl_pkg::ST_IDLE;
         age_ff   <= '0;
      end else begin
         state_ff <= state_in;
         age_ff   <= age_in;
      end
   end

endmodule

@@ hdl/erl_scan.sv @@
module erl_scan (
   input  logic               clock,
   input  logic               reset,
   input  erl_pkg::ctrl_type  ctrl,
   input  erl_pkg::slot_type  addr,
   input  logic               sent_bit,
   input  logic [7:0]         kind,
   output erl_pkg::slot_type  pend,
   output logic               found,
   output erl_pkg::count_type count
);

   logic               issue_q_ff;
   logic               found_ff;
   logic               run_ff;
   erl_pkg::slot_type  pend_ff;
   erl_pkg::count_type count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_q_ff <= 1'b0;
         found_ff   <= 1'b0;
         run_ff     <= 1'b0;
      end else if (ctrl.exec) begin
         issue_q_ff <= 1'b0;
         found_ff   <= 1'b0;
         run_ff     <= 1'b1;
      end else begin
         issue_q_ff <= ctrl.walk;
         // sent marks are flops, checked in the issue cycle
         if (ctrl.walk && !found_ff && !sent_bit) begin
            found_ff <= 1'b1;
         end
         // kind arrives in the cycle after its address
         if (issue_q_ff && run_ff && kind == 8'd0) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         pend_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (ctrl.walk && !found_ff && !sent_bit) begin
            pend_ff <= addr;
         end
         if (issue_q_ff && run_ff && kind != 8'd0) begin
            count_ff <= count_ff + erl_pkg::count_type'(1);
         end
      end
   end

   assign pend  = pend_ff;
   assign found = found_ff;
   assign count = count_ff;

endmodule
